// ----- rtl/radix_integer_text_parser_top_defines.svh -----
// ---------------------------------------------------------------------------
// Radix integer text parser - assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ---------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TEXT_PARSER_TOP_DEFINES_SVH
`define RADIX_INTEGER_TEXT_PARSER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define RITP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RITP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/ritp_pkg.sv -----
// ---------------------------------------------------------------------------
// ritp_pkg
// Types and constants of the radix integer text parser.
// ---------------------------------------------------------------------------
package ritp_pkg;

   localparam int RSP_VALUE_W = 64;
   localparam int COUNT_W     = 8;
   localparam int RADIX_W     = 6;
   localparam int CSR_DATA_W  = 6;

   // Register indexes on the CSR port
   localparam logic CSR_RADIX       = 1'b0;
   localparam logic CSR_SIGNED_MODE = 1'b1;

   // Reset values of the registers
   localparam logic [RADIX_W-1:0] RADIX_RESET       = 6'd10;
   localparam logic               SIGNED_MODE_RESET = 1'b1;

   // Characters of interest
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
   localparam logic [7:0] CH_UP_Z  = 8'h5a;  // 'Z'
   localparam logic [7:0] CH_LOW_A = 8'h61;  // 'a'
   localparam logic [7:0] CH_LOW_Z = 8'h7a;  // 'z'
   localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
   localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
   localparam logic [5:0] LETTER_BASE = 6'd10;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_COLLECT = 2'd1
   } phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       begin_req;
   } req_word_type;

   typedef struct packed {
      logic [RSP_VALUE_W-1:0] value;
      logic [COUNT_W-1:0]     consumed;
   } rsp_word_type;

   // Handshake between the input register and the parse stage
   typedef struct packed {
      logic valid;
      logic take;
   } stage_ctl_type;

endpackage

// ----- rtl/radix_integer_text_parser_top.sv -----
// ---------------------------------------------------------------------------
// radix_integer_text_parser_top
// Parses an integer in a configurable base from a character stream.
// ---------------------------------------------------------------------------
// The block takes one character word per cycle except while it stalls. A word
// goes into an input register, from which the parse stage classifies it and
// folds it into the accumulator with a single VALUE_BITS by 6 multiply-add by
// the radix; that multiply-add is the longest path. The word that ends a parse
// loads the result register when the parse stage takes it from the input
// register, and the result is held there until it is taken. While a result
// waits in the output register the block keeps accepting characters; it stalls
// only when a second result is due before the first one is taken.
// Write radix and signed_mode only while no parse is in flight.
// ---------------------------------------------------------------------------
module radix_integer_text_parser_top
   import ritp_pkg::*;
#(
   parameter int VALUE_BITS = 64,
   parameter int MAX_CHARS  = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word
);

   req_word_type  stage_word;
   logic          stage_valid;
   stage_ctl_type stage_ctl;

   ritp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .stage_word  (stage_word),
      .stage_valid (stage_valid),
      .stage_take  (stage_ctl.take)
   );

   ritp_core #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_CHARS  (MAX_CHARS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .stage_word   (stage_word),
      .stage_ctl    (stage_ctl),
      .stage_valid  (stage_valid),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word)
   );

endmodule

// ----- rtl/ritp_in_stage.sv -----
// ---------------------------------------------------------------------------
// ritp_in_stage
// Input register: holds one request word until the parse stage takes it.
// ---------------------------------------------------------------------------
module ritp_in_stage
   import ritp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_word_type  req_word,
   output req_word_type  stage_word,
   output logic          stage_valid,
   input  logic          stage_take
);

   logic         valid_ff, valid_in;
   req_word_type word_ff,  word_in;

   // Free when empty or when the held word leaves this cycle
   assign req_ready = !valid_ff || stage_take;

   always_comb begin
      valid_in = req_ready ? req_valid : valid_ff;
      word_in  = (req_valid && req_ready) ? req_word : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign stage_valid = valid_ff;
   assign stage_word  = word_ff;

endmodule

// ----- rtl/ritp_core.sv -----
// ---------------------------------------------------------------------------
// ritp_core
// Parse stage: config registers, parse state, one multiply-add per word,
// and the result register.
// ---------------------------------------------------------------------------
`include "radix_integer_text_parser_top_defines.svh"

module ritp_core
   import ritp_pkg::*;
#(
   parameter int VALUE_BITS = 64,
   parameter int MAX_CHARS  = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_word_type          stage_word,
   output stage_ctl_type         stage_ctl,
   input  logic                  stage_valid,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word
);

   localparam logic [COUNT_W-1:0] CountCap =
      COUNT_W'((MAX_CHARS < 255) ? MAX_CHARS : 255);

   // Config registers
   logic [RADIX_W-1:0] radix_ff;
   logic               signed_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= RADIX_RESET;
         signed_mode_ff <= SIGNED_MODE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_RADIX:       radix_ff       <= csr_wdata[RADIX_W-1:0];
            CSR_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   // Parse state
   phase_type             phase_ff, phase_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  minus_ff, minus_in;
   logic                  sign_ff, sign_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   // Character classification
   logic                  digit_ok;
   logic [5:0]            digit;
   logic                  is_sign;
   logic                  active;
   logic                  produce;
   logic                  out_free;
   logic                  advance;

   // Values the word starts from (begin clears them)
   logic [VALUE_BITS-1:0] acc_base;
   logic [COUNT_W-1:0]    count_base;
   logic                  minus_base;
   logic                  sign_base;
   logic [VALUE_BITS-1:0] product;
   logic [VALUE_BITS-1:0] signed_val;
   logic                  any_digit;

   always_comb begin
      digit_ok = 1'b1;
      digit    = 6'd0;
      if (stage_word.ch >= CH_ZERO && stage_word.ch <= CH_NINE) begin
         digit = 6'(stage_word.ch - CH_ZERO);
      end else if (stage_word.ch >= CH_UP_A && stage_word.ch <= CH_UP_Z) begin
         digit = 6'(stage_word.ch - CH_UP_A) + LETTER_BASE;
      end else if (stage_word.ch >= CH_LOW_A && stage_word.ch <= CH_LOW_Z) begin
         digit = 6'(stage_word.ch - CH_LOW_A) + LETTER_BASE;
      end else begin
         digit_ok = 1'b0;
      end
   end

   wire is_digit = digit_ok && (digit < radix_ff);

   assign is_sign = (stage_word.ch == CH_PLUS) ||
                    ((stage_word.ch == CH_MINUS) && signed_mode_ff);

   assign active = stage_valid && (stage_word.begin_req || (phase_ff == PHASE_COLLECT));

   always_comb begin
      acc_base   = stage_word.begin_req ? '0 : acc_ff;
      count_base = stage_word.begin_req ? '0 : count_ff;
      minus_base = stage_word.begin_req ? 1'b0 : minus_ff;
      sign_base  = stage_word.begin_req ? 1'b0 : sign_ff;
   end

   // Multiply-add by the radix, wrapping at VALUE_BITS
   assign product    = acc_base * VALUE_BITS'(radix_ff);
   assign signed_val = minus_base ? (~acc_base + 1'b1) : acc_base;
   assign any_digit  = count_base > COUNT_W'(sign_base);

   // A word ends the parse when it is neither a leading sign nor a digit
   assign produce  = active && !(stage_word.begin_req && is_sign) && !is_digit;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = stage_valid && (!produce || out_free);

   assign stage_ctl.valid = stage_valid;
   assign stage_ctl.take  = advance;

   // Next parse state
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      minus_in = minus_ff;
      sign_in  = sign_ff;
      if (advance && active) begin
         if (stage_word.begin_req && is_sign) begin
            phase_in = PHASE_COLLECT;
            acc_in   = '0;
            count_in = (CountCap != '0) ? COUNT_W'(1) : '0;
            minus_in = (stage_word.ch == CH_MINUS);
            sign_in  = 1'b1;
         end else if (is_digit) begin
            phase_in = PHASE_COLLECT;
            acc_in   = product + VALUE_BITS'(digit);
            count_in = (count_base < CountCap) ? count_base + 1'b1 : count_base;
            minus_in = minus_base;
            sign_in  = sign_base;
         end else begin
            phase_in = PHASE_IDLE;
            acc_in   = '0;
            count_in = '0;
            minus_in = 1'b0;
            sign_in  = 1'b0;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (advance && produce) begin
         rsp_valid_in         = 1'b1;
         rsp_word_in.value    = any_digit ? RSP_VALUE_W'(signed_val) : '0;
         rsp_word_in.consumed = any_digit ? count_base : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         acc_ff       <= '0;
         count_ff     <= '0;
         minus_ff     <= 1'b0;
         sign_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         minus_ff     <= minus_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks
   `RITP_ASSERT(a_idle_clean, (phase_ff == PHASE_IDLE) |-> (acc_ff == '0 && count_ff == '0 && !minus_ff && !sign_ff), "idle phase with leftover parse state")
   `RITP_ASSERT(a_no_overwrite, (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_word_ff)), "pending result lost or changed")
   `RITP_ASSERT(a_minus_needs_sign, minus_ff |-> sign_ff, "minus recorded without a sign")
   `RITP_ASSERT(a_sign_counted, sign_ff |-> (phase_ff == PHASE_COLLECT && count_ff != '0), "sign taken but not counted")
   `RITP_ASSERT(a_count_cap, count_ff <= CountCap, "character count above cap")

endmodule
